// ===== rtl/bpcm_pkg.sv =====
// ---------------------------------------------------------------------------
// bpcm_pkg: shared definitions for the balance PWM with charge meter
// Constants, microcode encodings, control and status structs, and the
// microcode program ROM.
// ---------------------------------------------------------------------------
package bpcm_pkg;

	// Fixed arithmetic constants.
	localparam logic [15:0] PERIOD_TICKS = 16'd1000;
	localparam logic [7:0]  PHASE_WRAP   = 8'd255;
	localparam logic [9:0]  MV_SCALE     = 10'd1000;
	localparam int          NUM_W        = 40;  // mV * on * 1000 fits in 40 bits
	localparam int          DVS_W        = 20;  // 36 * 16383 fits in 20 bits
	localparam int          PROD_W       = 23;  // mV * 1000
	localparam int          QCNT_W       = 6;
	localparam logic [QCNT_W-1:0] QCNT_INIT = QCNT_W'(NUM_W - 1);
	localparam logic [13:0] RES_RESET    = 14'd440;

	// Microcode widths.
	localparam int OP_W  = 3;
	localparam int CND_W = 3;
	localparam int PC_W  = 4;

	// Datapath operations.
	localparam logic [OP_W-1:0] OP_NOP  = 3'd0;
	localparam logic [OP_W-1:0] OP_TICK = 3'd1;
	localparam logic [OP_W-1:0] OP_MUL1 = 3'd2;
	localparam logic [OP_W-1:0] OP_MUL2 = 3'd3;
	localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
	localparam logic [OP_W-1:0] OP_ACC  = 3'd5;
	localparam logic [OP_W-1:0] OP_STOP = 3'd6;
	localparam logic [OP_W-1:0] OP_PUB  = 3'd7;

	// Jump conditions; a step jumps to its target when its condition holds.
	localparam logic [CND_W-1:0] CND_NEXT     = 3'd0;
	localparam logic [CND_W-1:0] CND_ALWAYS   = 3'd1;
	localparam logic [CND_W-1:0] CND_NO_START = 3'd2;
	localparam logic [CND_W-1:0] CND_STOP     = 3'd3;
	localparam logic [CND_W-1:0] CND_NO_CHG   = 3'd4;
	localparam logic [CND_W-1:0] CND_DIV_RUN  = 3'd5;
	localparam logic [CND_W-1:0] CND_OUT_BUSY = 3'd6;

	// Program addresses.
	localparam logic [PC_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [PC_W-1:0] ST_DECODE = 4'd1;
	localparam logic [PC_W-1:0] ST_TICK   = 4'd2;
	localparam logic [PC_W-1:0] ST_MUL1   = 4'd3;
	localparam logic [PC_W-1:0] ST_MUL2   = 4'd4;
	localparam logic [PC_W-1:0] ST_DIV    = 4'd5;
	localparam logic [PC_W-1:0] ST_ACC    = 4'd6;
	localparam logic [PC_W-1:0] ST_STOP   = 4'd7;
	localparam logic [PC_W-1:0] ST_WAIT   = 4'd8;
	localparam logic [PC_W-1:0] ST_PUB    = 4'd9;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [CND_W-1:0] cnd;
		logic [PC_W-1:0]  target;
	} ucw_t;

	typedef struct packed {
		logic start;
		logic is_stop;
		logic no_charge;
		logic div_run;
		logic out_busy;
	} dp_status_t;

	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		ucw_t w;
		begin
			case (pc)
				ST_IDLE:   w = '{OP_NOP,  CND_NO_START, ST_IDLE};
				ST_DECODE: w = '{OP_NOP,  CND_STOP,     ST_STOP};
				ST_TICK:   w = '{OP_TICK, CND_NEXT,     ST_IDLE};
				ST_MUL1:   w = '{OP_MUL1, CND_NO_CHG,   ST_WAIT};
				ST_MUL2:   w = '{OP_MUL2, CND_NEXT,     ST_IDLE};
				ST_DIV:    w = '{OP_DIV,  CND_DIV_RUN,  ST_DIV};
				ST_ACC:    w = '{OP_ACC,  CND_ALWAYS,   ST_WAIT};
				ST_STOP:   w = '{OP_STOP, CND_NEXT,     ST_IDLE};
				ST_WAIT:   w = '{OP_NOP,  CND_OUT_BUSY, ST_WAIT};
				ST_PUB:    w = '{OP_PUB,  CND_ALWAYS,   ST_IDLE};
				default:   w = '{OP_NOP,  CND_ALWAYS,   ST_IDLE};
			endcase
			return w;
		end
	endfunction

endpackage

// ===== rtl/bpcm_seq.sv =====
// ---------------------------------------------------------------------------
// bpcm_seq: microcode sequencer
// Step counter, program ROM lookup and conditional jump logic.
// ---------------------------------------------------------------------------
module bpcm_seq import bpcm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_status_t       status,
	output logic [OP_W-1:0]  op,
	output logic             idle
);

	logic [PC_W-1:0] pc_q;
	ucw_t            cw;
	logic            take;

	always_comb begin
		cw = ucode(pc_q);
		case (cw.cnd)
			CND_NEXT:     take = 1'b0;
			CND_ALWAYS:   take = 1'b1;
			CND_NO_START: take = !status.start;
			CND_STOP:     take = status.is_stop;
			CND_NO_CHG:   take = status.no_charge;
			CND_DIV_RUN:  take = status.div_run;
			CND_OUT_BUSY: take = status.out_busy;
			default:      take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= take ? cw.target : pc_q + PC_W'(1);
		end
	end

	assign op   = cw.op;
	assign idle = (pc_q == ST_IDLE);

endmodule

// ===== rtl/bpcm_dp.sv =====
// ---------------------------------------------------------------------------
// bpcm_dp: datapath
// PWM counters, charge multiplier, bit-serial divider, accumulator and
// result register, each step selected by the microcode operation.
// ---------------------------------------------------------------------------
module bpcm_dp import bpcm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [OP_W-1:0]  op,
	input  logic             accept,
	input  logic             opcode,
	input  logic [7:0]       duty_setpoint,
	input  logic [12:0]      cell_millivolts,
	input  logic [13:0]      res_centiohm,
	input  logic             out_stall,
	output dp_status_t       status,
	output logic             out_valid,
	output logic             load_on,
	output logic [47:0]      charge_total,
	output logic             charge_updated
);

	logic              opcode_q;
	logic [7:0]        duty_q;
	logic [12:0]       mv_q;
	logic [7:0]        phase_q;
	logic [15:0]       period_q;
	logic [15:0]       on_q;
	logic [47:0]       acc_q;
	logic [PROD_W-1:0] prod_q;
	logic [NUM_W-1:0]  num_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [QCNT_W-1:0] qcnt_q;
	logic              load_on_q;
	logic              upd_q;
	logic              out_valid_q;
	logic              out_load_on_q;
	logic [47:0]       out_total_q;
	logic              out_upd_q;

	logic [7:0]        phase_inc;
	logic [7:0]        phase_nxt;
	logic              on_nxt;
	logic [13:0]       r_eff;
	logic [DVS_W-1:0]  dvs_nxt;
	logic [DVS_W:0]    rem_sh;
	logic [DVS_W:0]    rem_sub;
	logic              rem_ge;
	logic              publish;
	logic [PROD_W+15:0] num_prod;

	always_comb begin
		phase_inc = phase_q + 8'd1;
		phase_nxt = (phase_inc == PHASE_WRAP) ? 8'd0 : phase_inc;
		on_nxt    = (phase_nxt <= duty_q);
		// A zero resistance setting is treated as one.
		r_eff     = (res_centiohm == 14'd0) ? 14'd1 : res_centiohm;
		dvs_nxt   = {1'b0, r_eff, 5'b0} + {4'b0, r_eff, 2'b0};
		num_prod  = prod_q * on_q;
		rem_sh    = {rem_q, num_q[NUM_W-1]};
		rem_sub   = rem_sh - {1'b0, dvs_q};
		rem_ge    = (rem_sh >= {1'b0, dvs_q});
		publish   = (op == OP_PUB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			period_q <= '0;
			on_q     <= '0;
			acc_q    <= '0;
		end else begin
			case (op)
				OP_TICK: begin
					phase_q  <= phase_nxt;
					period_q <= period_q + 16'd1;
					if (on_nxt) begin
						on_q <= on_q + 16'd1;
					end
				end
				OP_ACC: begin
					acc_q    <= acc_q + {8'b0, num_q};
					period_q <= '0;
					on_q     <= '0;
				end
				OP_STOP: begin
					period_q <= '0;
					on_q     <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Per-transaction working registers; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q  <= opcode;
			duty_q    <= duty_setpoint;
			mv_q      <= cell_millivolts;
			load_on_q <= 1'b0;
			upd_q     <= 1'b0;
		end
		case (op)
			OP_TICK: begin
				load_on_q <= on_nxt;
			end
			OP_MUL1: begin
				prod_q <= {10'b0, mv_q} * PROD_W'(MV_SCALE);
				dvs_q  <= dvs_nxt;
			end
			OP_MUL2: begin
				num_q  <= NUM_W'(num_prod);
				rem_q  <= '0;
				qcnt_q <= QCNT_INIT;
			end
			OP_DIV: begin
				// Restoring division, one quotient bit per step.
				rem_q  <= rem_ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
				num_q  <= {num_q[NUM_W-2:0], rem_ge};
				qcnt_q <= qcnt_q - QCNT_W'(1);
			end
			OP_ACC: begin
				upd_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (publish) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (publish) begin
			out_load_on_q <= load_on_q;
			out_total_q   <= acc_q;
			out_upd_q     <= upd_q;
		end
	end

	always_comb begin
		status.start     = accept;
		status.is_stop   = opcode_q;
		status.no_charge = (period_q != PERIOD_TICKS) || (on_q == 16'd0);
		status.div_run   = (qcnt_q != '0);
		status.out_busy  = out_valid_q && out_stall;
	end

	assign out_valid      = out_valid_q;
	assign load_on        = out_load_on_q;
	assign charge_total   = out_total_q;
	assign charge_updated = out_upd_q;

endmodule

// ===== rtl/balance_pwm_with_charge_meter.sv =====
// ---------------------------------------------------------------------------
// balance_pwm_with_charge_meter: PWM bypass control with charge metering
// A tick runs decode, tick, the charge check, output wait and publish; a stop
// runs decode, stop, wait and publish; a tick that closes a charged period adds
// the multiply steps, the 40-step divider and the accumulate step. One
// transaction is in flight at a time; the next can be accepted in the same cycle as the result appears.
// Reset clears the phase, period and on-tick counters and the accumulator; resistance resets to 440.
// ---------------------------------------------------------------------------
module balance_pwm_with_charge_meter import bpcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  duty_setpoint,
	input  logic [12:0] cell_millivolts,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        load_on,
	output logic [47:0] charge_total,
	output logic        charge_updated
);

	logic [13:0]     res_q;
	logic [OP_W-1:0] op;
	logic            idle;
	logic            accept;
	dp_status_t      status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= RES_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			res_q <= pwdata[13:0];
		end
	end

	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == 1'b0) ? {18'b0, res_q} : 32'd0;
	assign in_stall = !idle;
	assign accept   = in_valid && idle;

	bpcm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op),
		.idle   (idle)
	);

	bpcm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (op),
		.accept          (accept),
		.opcode          (opcode),
		.duty_setpoint   (duty_setpoint),
		.cell_millivolts (cell_millivolts),
		.res_centiohm    (res_q),
		.out_stall       (out_stall),
		.status          (status),
		.out_valid       (out_valid),
		.load_on         (load_on),
		.charge_total    (charge_total),
		.charge_updated  (charge_updated)
	);

endmodule

// ===== test/tb_balance_pwm_with_charge_meter.sv =====
// ---------------------------------------------------------------------------
// tb_balance_pwm_with_charge_meter: self-checking bench for the balance PWM
// Drives tick and stop commands with random bursts and gaps, stalls the
// result side on a changing pattern, and compares every result with a
// cycle-free model of the phase, period, on-tick and charge counters.
// The load resistance is reprogrammed between phases, extremes included.
// ---------------------------------------------------------------------------
module tb_balance_pwm_with_charge_meter;

	localparam logic       OPC_TICK      = 1'b0;
	localparam logic       OPC_STOP      = 1'b1;
	localparam logic [2:0] ADDR_LOAD_RES = 3'd0;
	localparam logic [15:0] PERIOD_LEN   = 16'd1000;
	localparam logic [7:0] PHASE_TOP     = 8'd255;
	localparam logic [13:0] RES_AT_RESET = 14'd440;
	localparam int         QUIET_LIMIT   = 3000;
	localparam int         SETTLE_CYCLES = 80;
	localparam int         RANDOM_ITEMS  = 1750;

	typedef struct packed {
		logic        opcode;
		logic [7:0]  duty;
		logic [12:0] millivolts;
	} pwm_cmd_t;

	typedef struct packed {
		logic        load_on;
		logic [47:0] charge_total;
		logic        charge_updated;
	} meter_reading_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = 1'b0;
	logic [7:0]  duty_setpoint = '0;
	logic [12:0] cell_millivolts = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        load_on;
	logic [47:0] charge_total;
	logic        charge_updated;

	balance_pwm_with_charge_meter dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.duty_setpoint(duty_setpoint),
		.cell_millivolts(cell_millivolts),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.load_on(load_on),
		.charge_total(charge_total),
		.charge_updated(charge_updated)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Model state, starting from the reset values.
	logic [7:0]  m_phase = '0;
	logic [15:0] m_period = '0;
	logic [15:0] m_on = '0;
	logic [47:0] m_charge = '0;
	logic [13:0] m_res = RES_AT_RESET;

	pwm_cmd_t       pending_cmds[$];
	meter_reading_t expected_readings[$];

	bit presenting = 1'b0;
	int errors = 0;
	int accepted_count = 0;
	int stop_count = 0;
	int charged_periods = 0;
	int settings_used = 0;

	// Generator bookkeeping: ticks since the last stop mirror the period counter,
	// because every run of 1000 ticks passes phase 0 and so has on-ticks.
	int gen_run = 0;
	int noise_left = 0;
	int random_items = 0;

	task automatic advance_meter(input pwm_cmd_t c);
		meter_reading_t r;
		logic [63:0] product;
		logic [63:0] divisor;
		r = '0;
		if (c.opcode == OPC_STOP) begin
			m_period = '0;
			m_on = '0;
			stop_count++;
		end else begin
			m_phase = m_phase + 8'd1;
			if (m_phase == PHASE_TOP)
				m_phase = '0;
			m_period = m_period + 16'd1;
			if (m_phase <= c.duty) begin
				r.load_on = 1'b1;
				m_on = m_on + 16'd1;
			end
			if (m_period == PERIOD_LEN && m_on != 16'd0) begin
				// A zero resistance setting counts as one hundredth of an ohm.
				divisor = 64'd36 * ((m_res == 14'd0) ? 64'd1 : 64'(m_res));
				product = 64'(c.millivolts) * 64'(m_on) * 64'd1000;
				m_charge = m_charge + 48'(product / divisor);
				m_on = '0;
				m_period = '0;
				r.charge_updated = 1'b1;
				charged_periods++;
			end
		end
		r.charge_total = m_charge;
		expected_readings.push_back(r);
	endtask

	function automatic void queue_cmd(input pwm_cmd_t c);
		pending_cmds.push_back(c);
		if (c.opcode == OPC_STOP) begin
			gen_run = 0;
		end else begin
			gen_run++;
			if (gen_run == int'(PERIOD_LEN)) begin
				gen_run = 0;
				// Now and then follow a completed period with a burst of broken ones.
				if ($urandom_range(0, 2) == 0)
					noise_left = $urandom_range(5, 30);
			end
		end
	endfunction

	function automatic pwm_cmd_t random_cmd();
		pwm_cmd_t c;
		if (noise_left > 0) begin
			c.opcode = ($urandom_range(0, 3) == 0) ? OPC_STOP : OPC_TICK;
			noise_left--;
		end else begin
			c.opcode = ($urandom_range(0, 1999) == 0) ? OPC_STOP : OPC_TICK;
		end
		case ($urandom_range(0, 9))
			0: c.duty = 8'd0;
			1: c.duty = 8'd255;
			default: c.duty = 8'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 9))
			0: c.millivolts = 13'd0;
			1, 2: c.millivolts = 13'd8191;
			default: c.millivolts = 13'($urandom_range(0, 8191));
		endcase
		return c;
	endfunction

	task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_load_resistance(input logic [31:0] word);
		logic [31:0] readback;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_LOAD_RES;
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		m_res = word[13:0];
		settings_used++;
		apb_read(ADDR_LOAD_RES, readback);
		if (readback !== {18'd0, m_res}) begin
			$error("load_resistance_centiohm: expected %0d, actual %0d", m_res, readback);
			errors++;
		end
	endtask

	task automatic wait_meter_idle();
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || presenting || expected_readings.size() != 0);
	endtask

	// Driver: one command presented at a time, in bursts separated by gaps.
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin : driver
		pwm_cmd_t taken;
		pwm_cmd_t next_cmd;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				taken.opcode = opcode;
				taken.duty = duty_setpoint;
				taken.millivolts = cell_millivolts;
				advance_meter(taken);
				presenting = 1'b0;
				accepted_count++;
			end
			if (!presenting) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					next_cmd = pending_cmds.pop_front();
					opcode <= next_cmd.opcode;
					duty_setpoint <= next_cmd.duty;
					cell_millivolts <= next_cmd.millivolts;
					in_valid <= 1'b1;
					presenting = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else if ($urandom_range(0, 3) == 0) begin
						burst_left = $urandom_range(100, 300);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(1, 20);
						gap_left = $urandom_range(1, 9);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result and drives a stall pattern that changes mode.
	int stall_mode = 0;
	int stall_left = 0;
	int stall_tick = 0;

	always @(posedge clk) begin : monitor
		meter_reading_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					$error("result with no transaction waiting: load_on %0b charge_total %0d",
						load_on, charge_total);
					errors++;
				end else begin
					want = expected_readings.pop_front();
					if (load_on !== want.load_on) begin
						$error("load_on: expected %0b, actual %0b", want.load_on, load_on);
						errors++;
					end
					if (charge_total !== want.charge_total) begin
						$error("charge_total: expected %0d, actual %0d",
							want.charge_total, charge_total);
						errors++;
					end
					if (charge_updated !== want.charge_updated) begin
						$error("charge_updated: expected %0b, actual %0b",
							want.charge_updated, charge_updated);
						errors++;
					end
				end
			end
			stall_tick++;
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 150);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 9) < 7);
				default: out_stall <= (stall_tick % 5) < 2;
			endcase
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_balance_pwm_with_charge_meter: done, errors");
		$finish;
	end

	initial begin : stimulus
		logic [31:0] readback;
		logic [31:0] res_plan[6];
		int plan_idx;
		pwm_cmd_t c;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_read(ADDR_LOAD_RES, readback);
		if (readback !== {18'd0, RES_AT_RESET}) begin
			$error("load_resistance_centiohm: expected %0d, actual %0d", RES_AT_RESET, readback);
			errors++;
		end

		// Directed: duty and voltage extremes, alternating bit patterns, stops
		// that override a full duty, and back-to-back stops.
		queue_cmd('{OPC_TICK, 8'd0,   13'd0});
		queue_cmd('{OPC_TICK, 8'd255, 13'd8191});
		queue_cmd('{OPC_TICK, 8'd2,   13'h1555});
		queue_cmd('{OPC_TICK, 8'd4,   13'h0AAA});
		queue_cmd('{OPC_STOP, 8'd255, 13'd8191});
		queue_cmd('{OPC_TICK, 8'hAA,  13'h1FFF});
		queue_cmd('{OPC_TICK, 8'h55,  13'd0});
		queue_cmd('{OPC_STOP, 8'd0,   13'd0});
		queue_cmd('{OPC_STOP, 8'hFF,  13'h1FFF});
		queue_cmd('{OPC_TICK, 8'd5,   13'd4096});
		queue_cmd('{OPC_TICK, 8'd255, 13'd1});
		queue_cmd('{OPC_TICK, 8'd0,   13'd8191});
		queue_cmd('{OPC_STOP, 8'd0,   13'd0});
		wait_meter_idle();

		// Resistance plan: a low value of 10, all ones (top of the 14-bit range), zero,
		// the reset value, a random one and an ordinary value.
		res_plan[0] = 32'd10;
		res_plan[1] = 32'hFFFF_FFFF;
		res_plan[2] = 32'd0;
		res_plan[3] = 32'd440;
		res_plan[4] = $urandom;
		res_plan[5] = 32'd1234;
		plan_idx = 0;

		while (random_items < RANDOM_ITEMS) begin
			wait_meter_idle();
			set_load_resistance(res_plan[plan_idx % 6]);
			plan_idx++;
			for (int chunk = 0; chunk < 12; chunk++) begin
				while (pending_cmds.size() >= 16)
					@(posedge clk);
				if (chunk == 6 && $urandom_range(0, 1) == 0)
					wait_meter_idle();
				for (int k = 0; k < 50; k++) begin
					c = random_cmd();
					queue_cmd(c);
					random_items++;
				end
			end
		end

		wait_meter_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d transactions, %0d of them stops, and %0d charged periods",
			accepted_count, stop_count, charged_periods);
		$display("across %0d load resistance settings; final charge %0d.",
			settings_used, m_charge);
		if (errors == 0)
			$display("tb_balance_pwm_with_charge_meter: done, clean");
		else
			$display("tb_balance_pwm_with_charge_meter: done, errors");
		$finish;
	end

endmodule
